// ===== rtl/core/pbes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbes_pkg;

  // Default limit of the device table
  localparam int unsigned MaxDevicesDefault = 64;

  // Config register offsets used by the scan
  localparam logic [7:0] OffIdent  = 8'h00;
  localparam logic [7:0] OffClass  = 8'h08;
  localparam logic [7:0] OffHeader = 8'h0C;
  localparam logic [7:0] OffIrq    = 8'h3C;

  // Vendor value of an empty function
  localparam logic [15:0] VendorNone = 16'hFFFF;

  // Highest bus, slot and function numbers
  localparam logic [7:0] LastBus  = 8'd255;
  localparam logic [4:0] LastSlot = 5'd31;
  localparam logic [2:0] LastFunc = 3'd7;

  // Bit of the header-type dword that marks a multifunction device
  localparam int unsigned MultiFuncBit = 23;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } in_kind_e;

  typedef enum logic [1:0] {
    RK_REQ  = 2'd0,
    RK_REC  = 2'd1,
    RK_DONE = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ID    = 3'd1,
    PH_CLASS = 3'd2,
    PH_IRQ   = 3'd3,
    PH_HDR   = 3'd4
  } phase_e;

  typedef struct packed {
    in_kind_e    kind;
    logic [31:0] read_data;
  } in_item_t;

  typedef struct packed {
    res_kind_e   result_kind;
    logic [7:0]  bus_num;
    logic [4:0]  slot_num;
    logic [2:0]  func_num;
    logic [7:0]  reg_offset;
    logic [15:0] vendor_id;
    logic [15:0] device_id;
    logic [31:0] class_word;
    logic [7:0]  intr_line;
    logic [6:0]  device_count;
    logic        overflow;
    logic        last;
  } res_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pbes_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbes_seq
  import pbes_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = MaxDevicesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      commit_i,
  input  wire in_item_t  item_i,
  output res_item_t      res0_o,
  output res_item_t      res1_o,
  output logic [1:0]     res_cnt_o
);

  localparam int unsigned CntW = $clog2(MAX_DEVICES + 1);

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  bus;
    logic [4:0]  slot;
    logic [2:0]  func;
    logic [31:0] held_ident;
    logic [31:0] held_class;
    logic        ovf;
  } seq_state_t;

  seq_state_t      st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Build a read request for the given location
  function automatic res_item_t mk_req(logic [7:0] bus, logic [4:0] slot,
                                       logic [2:0] func, logic [7:0] off);
    res_item_t r;
    r             = '0;
    r.result_kind = RK_REQ;
    r.bus_num     = bus;
    r.slot_num    = slot;
    r.func_num    = func;
    r.reg_offset  = off;
    return r;
  endfunction

  logic [CntW-1:0] done_cnt;
  logic            done_ovf;
  logic [CntW+6:0] cnt_ext;
  logic            table_full;
  res_item_t       done_res;
  res_item_t       rec_res;
  // Next-slot outcome
  seq_state_t      ns_st;
  res_item_t       ns_res;
  // Finish-function outcome
  seq_state_t      ff_st;
  res_item_t       ff_res;
  res_item_t       r0, r1;
  logic [1:0]      n;

  assign table_full = (cnt_q >= CntW'(MAX_DEVICES));

  // Count and overflow flag as they stand once this item is taken
  assign done_cnt = (st_q.phase == PH_IRQ) ? cnt_q + CntW'(1) : cnt_q;
  assign done_ovf = st_q.ovf || (st_q.phase == PH_ID && table_full &&
                                 item_i.read_data[15:0] != VendorNone);
  assign cnt_ext  = (CntW + 7)'(done_cnt);

  // Scan-done and device-record results
  always_comb begin
    done_res              = '0;
    done_res.result_kind  = RK_DONE;
    done_res.device_count = cnt_ext[6:0];
    done_res.overflow     = done_ovf;

    rec_res             = '0;
    rec_res.result_kind = RK_REC;
    rec_res.bus_num     = st_q.bus;
    rec_res.slot_num    = st_q.slot;
    rec_res.func_num    = st_q.func;
    rec_res.vendor_id   = st_q.held_ident[15:0];
    rec_res.device_id   = st_q.held_ident[31:16];
    rec_res.class_word  = st_q.held_class;
    rec_res.intr_line   = item_i.read_data[7:0];
  end

  // Advance to the next slot, or finish the scan after the last one
  always_comb begin
    ns_st      = st_q;
    ns_st.func = '0;
    ns_st.slot = st_q.slot + 5'd1;
    if (st_q.slot == LastSlot) begin
      ns_st.bus = st_q.bus + 8'd1;
    end
    if (st_q.slot == LastSlot && st_q.bus == LastBus) begin
      ns_st.phase = PH_IDLE;
      ns_res      = done_res;
    end else begin
      ns_st.phase = PH_ID;
      ns_res      = mk_req(ns_st.bus, ns_st.slot, ns_st.func, OffIdent);
    end
  end

  // Step to the next function of a multifunction device, else next slot
  always_comb begin
    if (st_q.func != '0 && st_q.func != LastFunc) begin
      ff_st       = st_q;
      ff_st.func  = st_q.func + 3'd1;
      ff_st.phase = PH_ID;
      ff_res      = mk_req(st_q.bus, st_q.slot, ff_st.func, OffIdent);
    end else begin
      ff_st  = ns_st;
      ff_res = ns_res;
    end
  end

  // Next state and results for the item in the input register
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    r0    = '0;
    r1    = '0;
    n     = 2'd0;
    if (item_i.kind == KIND_START) begin
      st_d.phase      = PH_ID;
      st_d.bus        = '0;
      st_d.slot       = '0;
      st_d.func       = '0;
      st_d.held_ident = '0;
      st_d.held_class = '0;
      st_d.ovf        = 1'b0;
      cnt_d           = '0;
      r0              = mk_req('0, '0, '0, OffIdent);
      n               = 2'd1;
    end else begin
      case (st_q.phase)
        PH_ID: begin
          n = 2'd1;
          if (item_i.read_data[15:0] == VendorNone) begin
            st_d = ff_st;
            r0   = ff_res;
          end else if (table_full) begin
            if (st_q.func == '0) begin
              st_d.phase = PH_HDR;
              r0         = mk_req(st_q.bus, st_q.slot, st_q.func, OffHeader);
            end else begin
              st_d = ff_st;
              r0   = ff_res;
            end
            st_d.ovf = 1'b1;
          end else begin
            st_d.held_ident = item_i.read_data;
            st_d.phase      = PH_CLASS;
            r0              = mk_req(st_q.bus, st_q.slot, st_q.func, OffClass);
          end
        end
        PH_CLASS: begin
          st_d.held_class = item_i.read_data;
          st_d.phase      = PH_IRQ;
          r0              = mk_req(st_q.bus, st_q.slot, st_q.func, OffIrq);
          n               = 2'd1;
        end
        PH_IRQ: begin
          r0    = rec_res;
          n     = 2'd2;
          cnt_d = cnt_q + CntW'(1);
          if (st_q.func == '0) begin
            st_d.phase = PH_HDR;
            r1         = mk_req(st_q.bus, st_q.slot, st_q.func, OffHeader);
          end else begin
            st_d = ff_st;
            r1   = ff_res;
          end
        end
        PH_HDR: begin
          n = 2'd1;
          if (item_i.read_data[MultiFuncBit]) begin
            st_d.func  = 3'd1;
            st_d.phase = PH_ID;
            r0         = mk_req(st_q.bus, st_q.slot, 3'd1, OffIdent);
          end else begin
            st_d = ns_st;
            r0   = ns_res;
          end
        end
        default: begin
          // Data while idle is dropped
          n = 2'd0;
        end
      endcase
    end
    // Flag the final result of this item
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign res0_o    = r0;
  assign res1_o    = r1;
  assign res_cnt_o = n;

  // Hold the scan state, advance it when an item is committed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_IDLE;
      st_q.bus        <= '0;
      st_q.slot       <= '0;
      st_q.func       <= '0;
      st_q.held_ident <= '0;
      st_q.held_class <= '0;
      st_q.ovf        <= 1'b0;
      cnt_q           <= '0;
    end else if (commit_i) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pbes_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbes_out_buf
  import pbes_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire logic [1:0] load_cnt_i,
  input  wire res_item_t load0_i,
  input  wire res_item_t load1_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output res_item_t      out_o
);

  res_item_t  ent_q [2];
  logic       head_q;
  logic [1:0] left_q;
  logic       pop;

  assign out_valid_o = (left_q != 2'd0);
  assign out_o       = ent_q[head_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a new pair once the last held result leaves
  assign free_o      = (left_q == 2'd0) || (left_q == 2'd1 && out_ready_i);

  // Track which held result goes out next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      left_q <= 2'd0;
    end else if (load_i) begin
      head_q <= 1'b0;
      left_q <= load_cnt_i;
    end else if (pop) begin
      head_q <= 1'b1;
      left_q <= left_q - 2'd1;
    end
  end

  // Capture the result pair
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q[0] <= load0_i;
      ent_q[1] <= load1_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pci_bus_enumeration_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Brute-force PCI enumeration sequencer. Send a start transaction, then feed
// back every config dword answering the last read request; each input yields
// the next read request, and a device record or the final scan-done result
// (with the recorded count and the overflow flag) where one is due. Data
// arriving while no scan runs is dropped; a start during a scan restarts it.
// An input is taken every cycle when it yields one result and the receiver is
// ready; after one that yields a device record plus a request, the next input
// waits until the record has left, as the result port delivers one transaction
// per cycle from a two-entry output buffer. Results pass the input register,
// then the output buffer. At most MAX_DEVICES devices are recorded.
module pci_bus_enumeration_sequencer
  import pbes_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = MaxDevicesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output res_item_t      out_o
);

  logic       in_vld_q;
  in_item_t   in_q;
  logic       buf_free;
  logic       commit;
  res_item_t  res0, res1;
  logic [1:0] res_cnt;

  assign commit     = in_vld_q && buf_free;
  assign in_ready_o = !in_vld_q || commit;

  // Hold the accepted transaction until the output buffer can take its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  pbes_seq #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (commit),
    .item_i    (in_q),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  pbes_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (commit),
    .load_cnt_i  (res_cnt),
    .load0_i     (res0),
    .load1_i     (res1),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
